// File: rtl/core/pwg_pkg.sv
package pwg_pkg;

  // Default generics of the generator
  localparam int unsigned LOWEST_TONE_HZ   = 20;
  localparam int unsigned MAX_PERIOD       = 4096;
  localparam int unsigned SINE_TABLE_DEPTH = 256;

  // Field widths
  localparam int unsigned RATE_W   = 16;
  localparam int unsigned FREQ_W   = 15;
  localparam int unsigned SEL_W    = 3;
  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned PHASE_W  = 16;   // Q0.16 phase fraction

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TONE_FREQ   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAVE_SEL    = 2'd2;

  localparam logic [RATE_W-1:0] RESET_SAMPLE_RATE = 16'd24000;
  localparam logic [FREQ_W-1:0] RESET_TONE_FREQ   = 15'd440;

  typedef enum logic [SEL_W-1:0] {
    WAVE_SINE     = 3'd0,
    WAVE_SQUARE   = 3'd1,
    WAVE_TRIANGLE = 3'd2,
    WAVE_SAW      = 3'd3,
    WAVE_SILENCE  = 3'd4
  } wave_sel_e;

  // Shared shift-subtract divider: one quotient bit per step
  localparam int unsigned DIV_STEPS = 16;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // Datapath operations issued by the microcode
  typedef enum logic [2:0] {
    OP_NONE,
    OP_START,    // capture transaction, set up rate / tone division
    OP_DIV,      // one divider step
    OP_PERIOD,   // saturate period, fix up phase index
    OP_MUL,      // index times tone
    OP_PHLOAD,   // set up phase division
    OP_SHAPE     // build sample, load output register, advance index
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   en;
  } ctrl_t;

  // Quarter-wave entry: 127 * sin(pi/2 * k / depth), six-term Taylor series in Q30.
  // Evaluated at elaboration only.
  function automatic logic [6:0] sine_entry(int unsigned k, int unsigned log2_depth);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] mag;
    logic [63:0] v;
    longint      sum;
    x   = (64'd1686629713 * 64'(k)) >> log2_depth;
    x2  = (x * x) >> 30;
    sum = longint'(x);
    mag = ((x * x2) >> 30) / 64'd6;
    sum = sum - longint'(mag);
    mag = ((mag * x2) >> 30) / 64'd20;
    sum = sum + longint'(mag);
    mag = ((mag * x2) >> 30) / 64'd42;
    sum = sum - longint'(mag);
    mag = ((mag * x2) >> 30) / 64'd72;
    sum = sum + longint'(mag);
    mag = ((mag * x2) >> 30) / 64'd110;
    sum = sum - longint'(mag);
    if (sum < 0) begin
      sum = 0;
    end
    v = (64'(sum) * 64'd127) >> 30;
    if (v > 64'd127) begin
      v = 64'd127;
    end
    return v[6:0];
  endfunction

endpackage

// File: rtl/core/pwg_req_if.sv
interface pwg_req_if;
  logic valid;
  logic ready;
  logic restart_phase;

  modport source (output valid, output restart_phase, input ready);
  modport sink (input valid, input restart_phase, output ready);
endinterface

// File: rtl/core/pwg_rsp_if.sv
interface pwg_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [pwg_pkg::SAMPLE_W-1:0]     sample_value;
  logic                             period_start;

  modport source (output valid, output sample_value, output period_start, input ready);
  modport sink (input valid, input sample_value, input period_start, output ready);
endinterface

// File: rtl/core/pwg_seq.sv
module pwg_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           out_full_i,
  input  logic           div_last_i,
  output logic           in_ready_o,
  output pwg_pkg::ctrl_t ctrl_o
);

  typedef enum logic [1:0] {
    C_NONE,
    C_NO_INPUT,
    C_DIV_MORE,
    C_OUT_FULL
  } cond_e;

  typedef struct packed {
    pwg_pkg::dp_op_e op;
    cond_e           cond;
    logic [2:0]      target;
    logic            op_on_jump;
    logic            last;
  } uword_t;

  localparam logic [2:0] S_WAIT = 3'd0;
  localparam logic [2:0] S_DIVP = 3'd1;
  localparam logic [2:0] S_PER  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_LDPH = 3'd4;
  localparam logic [2:0] S_DIVF = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] step_q, step_d;
  uword_t     word;
  logic       take;

  // Microprogram
  always_comb begin
    unique case (step_q)
      S_WAIT:  word = '{pwg_pkg::OP_START,  C_NO_INPUT, S_WAIT, 1'b0, 1'b0};
      S_DIVP:  word = '{pwg_pkg::OP_DIV,    C_DIV_MORE, S_DIVP, 1'b1, 1'b0};
      S_PER:   word = '{pwg_pkg::OP_PERIOD, C_NONE,     S_WAIT, 1'b0, 1'b0};
      S_MUL:   word = '{pwg_pkg::OP_MUL,    C_NONE,     S_WAIT, 1'b0, 1'b0};
      S_LDPH:  word = '{pwg_pkg::OP_PHLOAD, C_NONE,     S_WAIT, 1'b0, 1'b0};
      S_DIVF:  word = '{pwg_pkg::OP_DIV,    C_DIV_MORE, S_DIVF, 1'b1, 1'b0};
      S_OUT:   word = '{pwg_pkg::OP_SHAPE,  C_OUT_FULL, S_OUT,  1'b0, 1'b1};
      default: word = '{pwg_pkg::OP_NONE,   C_NONE,     S_WAIT, 1'b0, 1'b1};
    endcase
  end

  always_comb begin
    unique case (word.cond)
      C_NONE:     take = 1'b0;
      C_NO_INPUT: take = !in_valid_i;
      C_DIV_MORE: take = !div_last_i;
      C_OUT_FULL: take = out_full_i;
      default:    take = 1'b0;
    endcase
    if (take) begin
      step_d = word.target;
    end else if (word.last) begin
      step_d = S_WAIT;
    end else begin
      step_d = step_q + 3'd1;
    end
  end

  assign in_ready_o = (word.cond == C_NO_INPUT);
  assign ctrl_o.op  = word.op;
  assign ctrl_o.en  = !take || word.op_on_jump;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= S_WAIT;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

// File: rtl/core/pwg_wave.sv
module pwg_wave #(
  parameter int unsigned SINE_TABLE_DEPTH = pwg_pkg::SINE_TABLE_DEPTH
) (
  input  logic [pwg_pkg::SEL_W-1:0]    wave_sel_i,
  input  logic [pwg_pkg::PHASE_W-1:0]  phase_i,
  output logic [pwg_pkg::SAMPLE_W-1:0] sample_o
);

  localparam int unsigned LD = $clog2(SINE_TABLE_DEPTH);

  logic [6:0]    rom [SINE_TABLE_DEPTH];
  logic [LD+1:0] pos;
  logic [1:0]    quad;
  logic [LD-1:0] off;
  logic [LD-1:0] addr;
  logic [6:0]    amp;
  logic [23:0]   trng_p;
  logic [24:0]   trng_c;
  logic [22:0]   saw_p;
  logic [9:0]    y;

  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
    localparam logic [6:0] ENT = pwg_pkg::sine_entry(k, LD);
    assign rom[k] = ENT;
  end

  // Quadrant and offset into the quarter wave
  assign pos  = phase_i[pwg_pkg::PHASE_W-1 -: LD+2];
  assign quad = pos[LD+1:LD];
  assign off  = pos[LD-1:0];
  // Odd quadrants run the table backwards; the top of the quarter is full scale
  assign addr = quad[0] ? (LD)'(-off) : off;
  assign amp  = (quad[0] && off == '0) ? 7'd127 : rom[addr];

  assign trng_p = 24'd254 * 24'(phase_i);
  assign trng_c = {1'b0, trng_p} + 25'd65535;
  assign saw_p  = 23'd127 * 23'(phase_i);

  always_comb begin
    case (wave_sel_i)
      pwg_pkg::WAVE_SINE: begin
        y = quad[1] ? 10'd128 - 10'(amp) : 10'd128 + 10'(amp);
      end
      pwg_pkg::WAVE_SQUARE: begin
        y = phase_i[pwg_pkg::PHASE_W-1] ? 10'd0 : 10'd255;
      end
      pwg_pkg::WAVE_TRIANGLE: begin
        if (!phase_i[pwg_pkg::PHASE_W-1]) begin
          y = 10'd128 + 10'(trng_p[23:16]);
        end else begin
          y = 10'd382 - 10'(trng_c[24:16]);
        end
      end
      pwg_pkg::WAVE_SAW: begin
        y = 10'd128 + 10'(saw_p[22:16]);
      end
      default: begin
        y = 10'd128;
      end
    endcase
  end

  assign sample_o = (y > 10'd255) ? 8'd255 : y[7:0];

endmodule

// File: rtl/core/pwg_dp.sv
module pwg_dp #(
  parameter int unsigned LOWEST_TONE_HZ   = pwg_pkg::LOWEST_TONE_HZ,
  parameter int unsigned MAX_PERIOD       = pwg_pkg::MAX_PERIOD,
  parameter int unsigned SINE_TABLE_DEPTH = pwg_pkg::SINE_TABLE_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pwg_pkg::ctrl_t                ctrl_i,
  input  logic [pwg_pkg::RATE_W-1:0]    sample_rate_i,
  input  logic [pwg_pkg::FREQ_W-1:0]    tone_freq_i,
  input  logic [pwg_pkg::SEL_W-1:0]     wave_sel_i,
  input  logic                          restart_phase_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [pwg_pkg::SAMPLE_W-1:0]  sample_value_o,
  output logic                          period_start_o,
  output logic                          div_last_o
);

  localparam int unsigned IDX_W  = $clog2(MAX_PERIOD);
  localparam int unsigned PER_W  = $clog2(MAX_PERIOD + 1);
  localparam int unsigned PROD_W = IDX_W + pwg_pkg::FREQ_W;
  localparam int unsigned DW     = pwg_pkg::RATE_W;

  logic [IDX_W-1:0]                 idx_q;
  logic [PER_W-1:0]                 period_q;
  logic [PROD_W-1:0]                prod_q;
  logic [DW-1:0]                    rem_q, dq_q, dvs_q;
  logic [pwg_pkg::DIV_CNT_W-1:0]    cnt_q;
  logic                             restart_q;
  logic                             zero_q, ovf_q;
  logic                             out_valid_q;
  logic [pwg_pkg::SAMPLE_W-1:0]     sample_q;
  logic                             start_q;

  logic [pwg_pkg::FREQ_W-1:0]       fc;
  logic [DW:0]                      rem_sh;
  logic                             ge;
  logic [DW:0]                      rem_nx;
  logic [PER_W-1:0]                 period_d;
  logic [PER_W-1:0]                 idx_ext;
  logic [PER_W-1:0]                 idx_inc;
  logic [pwg_pkg::PHASE_W-1:0]      phase;
  logic [pwg_pkg::SAMPLE_W-1:0]     sample;

  assign fc = (tone_freq_i < pwg_pkg::FREQ_W'(LOWEST_TONE_HZ)) ?
              pwg_pkg::FREQ_W'(LOWEST_TONE_HZ) : tone_freq_i;

  // Restoring divider step: remainder and dividend/quotient shift together
  assign rem_sh = {rem_q, dq_q[DW-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};
  assign rem_nx = ge ? rem_sh - {1'b0, dvs_q} : rem_sh;

  assign div_last_o = (cnt_q == pwg_pkg::DIV_CNT_W'(pwg_pkg::DIV_STEPS - 1));

  // Period saturates to 1..MAX_PERIOD
  always_comb begin
    if (dq_q == '0) begin
      period_d = PER_W'(1);
    end else if ({1'b0, dq_q} > (DW + 1)'(MAX_PERIOD)) begin
      period_d = PER_W'(MAX_PERIOD);
    end else begin
      period_d = PER_W'(dq_q);
    end
  end

  assign idx_ext = PER_W'(idx_q);
  assign idx_inc = idx_ext + PER_W'(1);
  assign phase   = zero_q ? '0 : (ovf_q ? '1 : dq_q);

  pwg_wave #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_wave (
    .wave_sel_i(wave_sel_i),
    .phase_i   (phase),
    .sample_o  (sample)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (ctrl_i.en) begin
        case (ctrl_i.op)
          pwg_pkg::OP_START: begin
            cnt_q <= '0;
          end
          pwg_pkg::OP_DIV: begin
            cnt_q <= cnt_q + 1'b1;
          end
          pwg_pkg::OP_PERIOD: begin
            if (restart_q || idx_ext >= period_d) begin
              idx_q <= '0;
            end
          end
          pwg_pkg::OP_PHLOAD: begin
            cnt_q <= '0;
          end
          pwg_pkg::OP_SHAPE: begin
            out_valid_q <= 1'b1;
            idx_q       <= (idx_inc >= period_q) ? '0 : idx_inc[IDX_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      case (ctrl_i.op)
        pwg_pkg::OP_START: begin
          restart_q <= restart_phase_i;
          rem_q     <= '0;
          dq_q      <= sample_rate_i;
          dvs_q     <= DW'(fc);
        end
        pwg_pkg::OP_DIV: begin
          rem_q <= rem_nx[DW-1:0];
          dq_q  <= {dq_q[DW-2:0], ge};
        end
        pwg_pkg::OP_PERIOD: begin
          period_q <= period_d;
        end
        pwg_pkg::OP_MUL: begin
          prod_q <= PROD_W'(idx_q) * PROD_W'(fc);
        end
        pwg_pkg::OP_PHLOAD: begin
          rem_q  <= prod_q[DW-1:0];
          dq_q   <= '0;
          dvs_q  <= sample_rate_i;
          zero_q <= (sample_rate_i == '0);
          ovf_q  <= (prod_q >= PROD_W'(sample_rate_i));
        end
        pwg_pkg::OP_SHAPE: begin
          sample_q <= sample;
          start_q  <= (idx_q == '0);
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sample_value_o = sample_q;
  assign period_start_o = start_q;

endmodule

// File: rtl/core/periodic_waveform_generator.sv
// The next request is taken only after the previous sample has been built, and the shared
// shift-subtract divider, used for both divisions of a request, runs 16 steps for the
//   period and 16 steps for the phase fraction.
// A finished sample waits in the output register while the next request is taken.
// Reset (rst_ni low, asynchronous): sample rate 24000, tone 440, silence selected,
//   phase index zero, sequencer back at its wait step, no result pending.
module periodic_waveform_generator #(
  parameter int unsigned LOWEST_TONE_HZ   = pwg_pkg::LOWEST_TONE_HZ,
  parameter int unsigned MAX_PERIOD       = pwg_pkg::MAX_PERIOD,
  parameter int unsigned SINE_TABLE_DEPTH = pwg_pkg::SINE_TABLE_DEPTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [pwg_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [pwg_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  pwg_req_if.sink                            req_if,
  pwg_rsp_if.source                          rsp_if
);

  logic [pwg_pkg::RATE_W-1:0] sample_rate_q;
  logic [pwg_pkg::FREQ_W-1:0] tone_freq_q;
  logic [pwg_pkg::SEL_W-1:0]  wave_sel_q;

  pwg_pkg::ctrl_t ctrl;
  logic           div_last;
  logic           out_valid;
  logic           in_ready;

  // Configuration registers; writes to unused indexes drop silently,
  // and each value is cut to its register width.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_rate_q <= pwg_pkg::RESET_SAMPLE_RATE;
      tone_freq_q   <= pwg_pkg::RESET_TONE_FREQ;
      wave_sel_q    <= pwg_pkg::WAVE_SILENCE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pwg_pkg::CFG_SAMPLE_RATE: sample_rate_q <= cfg_data_i[pwg_pkg::RATE_W-1:0];
        pwg_pkg::CFG_TONE_FREQ:   tone_freq_q   <= cfg_data_i[pwg_pkg::FREQ_W-1:0];
        pwg_pkg::CFG_WAVE_SEL:    wave_sel_q    <= cfg_data_i[pwg_pkg::SEL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Microcoded control: the step word picks a datapath operation, and the
  // sequencer holds on a step while it waits for a request, for the divider
  // to finish, or for the output register to drain.
  pwg_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(req_if.valid),
    .out_full_i(out_valid && !rsp_if.ready),
    .div_last_i(div_last),
    .in_ready_o(in_ready),
    .ctrl_o    (ctrl)
  );

  // Datapath: divider, index multiply, phase index, waveform shaper, output register
  pwg_dp #(
    .LOWEST_TONE_HZ  (LOWEST_TONE_HZ),
    .MAX_PERIOD      (MAX_PERIOD),
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .sample_rate_i  (sample_rate_q),
    .tone_freq_i    (tone_freq_q),
    .wave_sel_i     (wave_sel_q),
    .restart_phase_i(req_if.restart_phase),
    .out_ready_i    (rsp_if.ready),
    .out_valid_o    (out_valid),
    .sample_value_o (rsp_if.sample_value),
    .period_start_o (rsp_if.period_start),
    .div_last_o     (div_last)
  );

  assign req_if.ready = in_ready;
  assign rsp_if.valid = out_valid;

endmodule
